// ----- design/m4inv_pkg.sv -----
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared constants and saturating helpers for the 4x4 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package m4inv_pkg;

  localparam int NEL = 16;
  localparam int IDX_W = 4;

  // Saturation limits for 64-bit intermediates
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // Saturating add of two 64-bit signed values
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // Saturating subtract
  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // Saturating negate
  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    if (a == S64_MIN) return S64_MAX;
    return -a;
  endfunction

  // Magnitude of a 64-bit signed value
  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

endpackage

// ----- design/m4inv_ram.sv -----
// ----------------------------------------------------------------------------
// m4inv_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module m4inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/m4inv_fmul.sv -----
// ----------------------------------------------------------------------------
// m4inv_fmul
// Fixed-point multiplier: exact product over four 32x32 partial products,
// rounded half away from zero, saturated to 64 bits.
// ----------------------------------------------------------------------------
module m4inv_fmul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] p
);
  import m4inv_pkg::*;

  logic [63:0]  xm, ym;
  logic         neg;
  logic [2:0]   step;
  logic         busy;
  logic [127:0] acc;
  logic [31:0]  xs, ys;
  logic [63:0]  pp;
  logic [127:0] rnd;
  logic [127:0] shf;

  // Select the partial product for this step
  always_comb begin
    xs = step[0] ? xm[63:32] : xm[31:0];
    ys = step[1] ? ym[63:32] : ym[31:0];
    pp = xs * ys;
    rnd = acc + (128'd1 << (FRAC_BITS - 1));
    shf = rnd >> FRAC_BITS;
  end

  // Accumulate partial products, then round and saturate
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      xm   <= mag64(a);
      ym   <= mag64(b);
      neg  <= a[63] ^ b[63];
      acc  <= '0;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (step == 3'd4) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (shf[127:64] != 64'd0) p <= neg ? S64_MIN : S64_MAX;
        else if (neg) p <= shf[63] ? S64_MIN : -$signed(shf[63:0]);
        else p <= shf[63] ? S64_MAX : $signed(shf[63:0]);
      end else begin
        acc  <= acc + ({64'd0, pp} << (32 * (32'(step[0]) + 32'(step[1]))));
        step <= step + 3'd1;
      end
    end
  end

endmodule

// ----- design/m4inv_fdiv.sv -----
// ----------------------------------------------------------------------------
// m4inv_fdiv
// Restoring divider: adj * 2^FRAC_BITS / det, one quotient bit per cycle,
// rounded half away from zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module m4inv_fdiv #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [31:0] q
);
  import m4inv_pkg::*;

  logic [127:0] dividend;
  logic [63:0]  d;
  logic [64:0]  rem;
  logic [31:0]  quo;
  logic         big;
  logic         neg;
  logic         busy;
  logic [6:0]   pos;
  logic [64:0]  shifted;
  logic         ge;
  logic [64:0]  twice;
  logic [32:0]  qr;
  logic         fin;

  always_comb begin
    shifted = {rem[63:0], dividend[pos]};
    ge      = shifted >= {1'b0, d};
    twice   = {rem[63:0], 1'b0};
    qr      = {1'b0, quo} + ((twice >= {1'b0, d}) ? 33'd1 : 33'd0);
  end

  // Walk the 128-bit dividend from the top bit down
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      dividend <= {64'd0, mag64(num)} << FRAC_BITS;
      d        <= mag64(den);
      neg      <= num[63] ^ den[63];
      rem      <= '0;
      quo      <= '0;
      big      <= 1'b0;
      pos      <= 7'd127;
      busy     <= 1'b1;
    end else if (busy) begin
      rem <= ge ? shifted - {1'b0, d} : shifted;
      if (ge) begin
        if (pos >= 7'd32) big <= 1'b1;
        else quo[pos[4:0]] <= 1'b1;
      end
      pos <= pos - 7'd1;
      if (pos == 7'd0) busy <= 1'b0;
    end
    // Final rounding and saturation the cycle after the last bit
    if (!rst && !start && !busy && fin) begin
      done <= 1'b1;
      if (neg) begin
        if (big || qr > 33'h080000000) q <= 32'sh80000000;
        else q <= -$signed(qr[31:0]);
      end else begin
        if (big || qr > 33'h07fffffff) q <= 32'sh7fffffff;
        else q <= $signed(qr[31:0]);
      end
    end
  end

  // Mark the cycle right after the last bit
  always_ff @(posedge clk) begin
    if (rst) fin <= 1'b0;
    else fin <= busy && pos == 7'd0 && !start;
  end

endmodule

// ----- design/matrix4_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix4_inverse
// 4x4 signed fixed-point matrix inverse by the adjugate method.
// ----------------------------------------------------------------------------
// Sequence: after the last of the 16 elements, each of the 16 minors is built
// from nine element reads and nine products, then written; the determinant
// follows, then each adjugate entry is read, divided and emitted in turn.
// One matrix at a time: no input is taken until all 16 results are out; a
// singular matrix skips the division and emits zero values.
// Reset clears the load count, the sequencer and the output valid flag.
module matrix4_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] value, [35:32] position, [39:36] zero
  output logic        m_tuser,  // singular
  output logic        m_tlast   // last
);
  import m4inv_pkg::*;

  typedef enum logic [3:0] {
    LOAD, RD, RDW, MUL1, MUL1W, MUL2W, COMB, MINDONE, DETRD, DETMUL, DETW,
    DIVRD, DIVS, DIVW, EMIT
  } state_t;

  state_t state;

  // Element memory and adjugate memory
  logic              el_we;
  logic [IDX_W-1:0]  el_waddr, el_raddr;
  logic [31:0]       el_rdata;
  logic              adj_we;
  logic [IDX_W-1:0]  adj_waddr, adj_raddr;
  logic [63:0]       adj_wdata, adj_rdata;

  m4inv_ram #(.WIDTH(32), .DEPTH(NEL)) u_el (
    .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(s_tdata),
    .raddr(el_raddr), .rdata(el_rdata)
  );
  m4inv_ram #(.WIDTH(64), .DEPTH(NEL)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  logic [IDX_W-1:0]  load_count;
  logic [IDX_W-1:0]  mi;          // minor index r*4+c
  logic [3:0]        ri;          // element of the 3x3 being read 0..8
  logic signed [63:0] sub [9];
  logic [1:0]        term;        // 3x3 term 0..2
  logic              half;        // first or second product of a 2x2
  logic signed [63:0] pa, t2x2, acc3;
  logic signed [63:0] det;
  logic signed [63:0] m0 [4];
  logic [1:0]        dj;
  logic [IDX_W-1:0]  k;
  logic              mul_start, mul_done, div_start, div_done;
  logic signed [63:0] mul_a, mul_b, mul_p;
  logic signed [31:0] div_q;

  m4inv_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );
  m4inv_fdiv #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(adj_rdata), .den(det),
    .done(div_done), .q(div_q)
  );

  // Row and column of the ri-th element inside the 3x3
  logic [1:0] r_row, r_col, sr, sc;
  always_comb begin
    unique case (ri)
      4'd0:    begin sr = 2'd0; sc = 2'd0; end
      4'd1:    begin sr = 2'd0; sc = 2'd1; end
      4'd2:    begin sr = 2'd0; sc = 2'd2; end
      4'd3:    begin sr = 2'd1; sc = 2'd0; end
      4'd4:    begin sr = 2'd1; sc = 2'd1; end
      4'd5:    begin sr = 2'd1; sc = 2'd2; end
      4'd6:    begin sr = 2'd2; sc = 2'd0; end
      4'd7:    begin sr = 2'd2; sc = 2'd1; end
      default: begin sr = 2'd2; sc = 2'd2; end
    endcase
    // Skip the row and column of minor mi
    r_row = (sr >= mi[3:2]) ? sr + 2'd1 : sr;
    r_col = (sc >= mi[1:0]) ? sc + 2'd1 : sc;
  end

  // Operand pairs for the 3x3 terms: (e*i, f*h), (d*i, f*g), (d*h, e*g)
  logic [3:0] ia, ib;
  always_comb begin
    unique case (term)
      2'd0:    begin ia = half ? 4'd5 : 4'd4; ib = half ? 4'd7 : 4'd8; end
      2'd1:    begin ia = half ? 4'd5 : 4'd3; ib = half ? 4'd6 : 4'd8; end
      default: begin ia = half ? 4'd4 : 4'd3; ib = half ? 4'd6 : 4'd7; end
    endcase
  end

  assign s_tready = (state == LOAD);
  assign el_we    = s_tvalid && s_tready;
  assign el_waddr = load_count;
  assign el_raddr = (state == LOAD)  ? '0 :
                    (state == DETRD) ? {2'b00, dj} : {r_row, r_col};
  assign adj_raddr = k;
  assign adj_waddr = {mi[1:0], mi[3:2]};
  assign adj_wdata = (mi[2] ^ mi[0]) ? sat_neg(acc3) : acc3;

  always_comb begin
    mul_start = 1'b0;
    mul_a = sub[ia];
    mul_b = sub[ib];
    adj_we = 1'b0;
    div_start = 1'b0;
    case (state)
      MUL1:    mul_start = 1'b1;
      COMB:    begin
        mul_start = 1'b1;
        mul_a = sub[{2'b00, term}];
        mul_b = t2x2;
      end
      MINDONE: adj_we = 1'b1;
      DETMUL:  begin
        mul_start = 1'b1;
        mul_a = {{32{el_rdata[31]}}, el_rdata};
        mul_b = m0[dj];
      end
      DIVS:    div_start = (det != 64'sd0);
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      load_count <= '0;
      m_tvalid <= 1'b0;
      mi <= '0;
      ri <= '0;
    end else begin
      unique case (state)
        LOAD: if (el_we) begin
          load_count <= load_count + 1'b1;
          if (load_count == IDX_W'(NEL - 1)) begin
            state <= RD;
            mi <= '0;
            ri <= '0;
          end
        end
        RD: state <= RDW;
        RDW: begin
          sub[ri] <= {{32{el_rdata[31]}}, el_rdata};
          if (ri == 4'd8) begin
            state <= MUL1;
            term <= '0;
            half <= 1'b0;
            acc3 <= '0;
          end else begin
            ri <= ri + 4'd1;
            state <= RD;
          end
        end
        MUL1: state <= MUL1W;
        MUL1W: if (mul_done) begin
          if (!half) begin
            pa <= mul_p;
            half <= 1'b1;
            state <= MUL1;
          end else begin
            t2x2 <= sat_sub(pa, mul_p);
            half <= 1'b0;
            state <= COMB;
          end
        end
        COMB: state <= MUL2W;
        MUL2W: if (mul_done) begin
          acc3 <= (term == 2'd1) ? sat_sub(acc3, mul_p) : sat_add(acc3, mul_p);
          if (term == 2'd2) state <= MINDONE;
          else begin
            term <= term + 2'd1;
            state <= MUL1;
          end
        end
        MINDONE: begin
          if (mi[3:2] == 2'd0) m0[mi[1:0]] <= acc3;
          ri <= '0;
          if (mi == IDX_W'(NEL - 1)) begin
            state <= DETRD;
            dj <= '0;
            det <= '0;
            mi <= '0;
          end else begin
            mi <= mi + 1'b1;
            state <= RD;
          end
        end
        DETRD: state <= DETMUL;
        DETMUL: state <= DETW;
        DETW: if (mul_done) begin
          det <= dj[0] ? sat_sub(det, mul_p) : sat_add(det, mul_p);
          if (dj == 2'd3) begin
            k <= '0;
            state <= DIVRD;
          end else begin
            dj <= dj + 2'd1;
            state <= DETRD;
          end
        end
        DIVRD: state <= DIVS;
        DIVS: state <= DIVW;
        DIVW: if (det == 64'sd0 || div_done) begin
          m_tvalid <= 1'b1;
          m_tdata <= {4'd0, k, (det == 64'sd0) ? 32'd0 : div_q};
          m_tuser <= (det == 64'sd0);
          m_tlast <= (k == IDX_W'(NEL - 1));
          state <= EMIT;
        end
        EMIT: if (m_tready) begin
          m_tvalid <= 1'b0;
          if (k == IDX_W'(NEL - 1)) state <= LOAD;
          else begin
            k <= k + 1'b1;
            state <= DIVRD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  // Only load while no result is pending
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("input taken while result pending");
  // Multiplier done only when waiting on it
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == MUL1W || state == MUL2W || state == DETW))
    else $error("stray multiplier result");
  // Singular runs carry zero values
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
    else $error("singular item with nonzero value");

endmodule
